@@ src/iaalu_pkg.sv @@
// Shared types, codes and constants for the pipelined integer ALU.
// Used by every module of the ALU; depends on nothing.
package iaalu_pkg;

   localparam int DataWidth = 32;
   localparam int OpWidth   = 3;
   localparam int StWidth   = 2;
   localparam int HalfWidth = DataWidth / 2;

   localparam logic [OpWidth-1:0] OP_ADD = 3'd0;
   localparam logic [OpWidth-1:0] OP_SUB = 3'd1;
   localparam logic [OpWidth-1:0] OP_MUL = 3'd2;
   localparam logic [OpWidth-1:0] OP_DIV = 3'd3;
   localparam logic [OpWidth-1:0] OP_MOD = 3'd4;

   localparam logic [StWidth-1:0] ST_OK       = 2'd0;
   localparam logic [StWidth-1:0] ST_BAD_OP   = 2'd1;
   localparam logic [StWidth-1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [StWidth-1:0] ST_MOD_ZERO = 2'd3;

   // One slot travelling down the divider chain.
   typedef struct packed {
      logic                 valid;
      logic                 is_div;
      logic                 is_mod;
      logic                 q_neg;
      logic                 r_neg;
      logic [StWidth-1:0]   status;
      logic [DataWidth-1:0] fixed;      // result for non-divide operations
      logic [DataWidth-1:0] divisor;    // magnitude
      logic [DataWidth-1:0] quot;       // dividend bits shift out, quotient bits in
      logic [DataWidth:0]   rem;        // partial remainder
   } slot_type;

endpackage

@@ src/integer_alu_add_sub_mul_div_mod_core.sv @@
// Signed integer ALU: add, sub, mul, truncating div and remainder.
// Pipeline: two input stages, one divide cell per quotient bit, one output
// stage. Throughput: one transfer per cycle.
// The whole chain advances together and stalls only when the output is full
// and not taken. Synchronous active-high reset empties the chain.
// Depends on iaalu_pkg, iaalu_front and iaalu_cell.
module integer_alu_add_sub_mul_div_mod_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // op[2:0], left_operand[34:3], right_operand[66:35]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // result[31:0], status[33:32]
);
   import iaalu_pkg::*;

   logic                 advance;
   slot_type             chain [0:DataWidth];
   logic                 out_valid_ff;
   logic [DataWidth-1:0] out_result_ff;
   logic [StWidth-1:0]   out_status_ff;
   slot_type             tail;
   logic [DataWidth-1:0] div_res;
   logic [DataWidth-1:0] mod_res;

   assign advance    = ~out_valid_ff | rsp_tready;
   assign req_tready = advance;

   iaalu_front u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (req_tvalid),
      .op            (req_tdata[OpWidth-1:0]),
      .left_operand  (req_tdata[OpWidth+DataWidth-1:OpWidth]),
      .right_operand (req_tdata[OpWidth+2*DataWidth-1:OpWidth+DataWidth]),
      .slot_out      (chain[0])
   );

   for (genvar i = 0; i < DataWidth; i++) begin : g_cell
      iaalu_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .slot_in  (chain[i]),
         .slot_out (chain[i+1])
      );
   end

   assign tail = chain[DataWidth];

   always_comb begin
      div_res = tail.q_neg ? (-tail.quot) : tail.quot;
      mod_res = tail.r_neg ? (-tail.rem[DataWidth-1:0]) : tail.rem[DataWidth-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= tail.valid;
      end
      if (advance) begin
         out_status_ff <= tail.status;
         if (!tail.is_div) begin
            out_result_ff <= (tail.status == ST_OK) ? tail.fixed : '0;
         end else if (tail.is_mod) begin
            out_result_ff <= mod_res;
         end else begin
            out_result_ff <= div_res;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_status_ff, out_result_ff};

endmodule

@@ src/iaalu_cell.sv @@
// One restoring-divide step cell of the ALU chain; passes its slot on each cycle that the chain advances.
// Depends on iaalu_pkg.
module iaalu_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  iaalu_pkg::slot_type slot_in,
   output iaalu_pkg::slot_type slot_out
);
   import iaalu_pkg::*;

   slot_type            slot_ff;
   slot_type            slot_in_w;
   logic [DataWidth:0]  shifted;
   logic [DataWidth:0]  diff;

   always_comb begin
      slot_in_w = slot_in;
      shifted   = {slot_in.rem[DataWidth-1:0], slot_in.quot[DataWidth-1]};
      diff      = shifted - {1'b0, slot_in.divisor};
      if (diff[DataWidth]) begin
         slot_in_w.rem  = shifted;
         slot_in_w.quot = {slot_in.quot[DataWidth-2:0], 1'b0};
      end else begin
         slot_in_w.rem  = diff;
         slot_in_w.quot = {slot_in.quot[DataWidth-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff.valid <= slot_in.valid;
      end
      if (advance) begin
         slot_ff.is_div  <= slot_in_w.is_div;
         slot_ff.is_mod  <= slot_in_w.is_mod;
         slot_ff.q_neg   <= slot_in_w.q_neg;
         slot_ff.r_neg   <= slot_in_w.r_neg;
         slot_ff.status  <= slot_in_w.status;
         slot_ff.fixed   <= slot_in_w.fixed;
         slot_ff.divisor <= slot_in_w.divisor;
         slot_ff.quot    <= slot_in_w.quot;
         slot_ff.rem     <= slot_in_w.rem;
      end
   end

   assign slot_out = slot_ff;

endmodule

@@ src/iaalu_front.sv @@
// Input stage: decodes the operation, does add/sub, a split 32x32 multiply
// over two stages, and prepares divide magnitudes. Depends on iaalu_pkg.
module iaalu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [iaalu_pkg::OpWidth-1:0]   op,
   input  logic [iaalu_pkg::DataWidth-1:0] left_operand,
   input  logic [iaalu_pkg::DataWidth-1:0] right_operand,
   output iaalu_pkg::slot_type           slot_out
);
   import iaalu_pkg::*;

   // stage one registers
   logic                 valid_ff;
   logic [OpWidth-1:0]   op_ff;
   logic [DataWidth-1:0] a_ff;
   logic [DataWidth-1:0] b_ff;
   logic [DataWidth-1:0] lo_ff;      // a_lo * b_lo
   logic [DataWidth-1:0] cross_ff;   // a_lo*b_hi + a_hi*b_lo, low half used

   logic [DataWidth-1:0] lo_in;
   logic [DataWidth-1:0] cross_in;
   slot_type             slot_in;
   slot_type             slot_ff;
   logic [DataWidth-1:0] mag_a;
   logic [DataWidth-1:0] mag_b;
   logic [DataWidth-1:0] prod;

   always_comb begin
      lo_in    = DataWidth'(left_operand[HalfWidth-1:0])
               * DataWidth'(right_operand[HalfWidth-1:0]);
      cross_in = DataWidth'(left_operand[HalfWidth-1:0])
               * DataWidth'(right_operand[DataWidth-1:HalfWidth])
               + DataWidth'(left_operand[DataWidth-1:HalfWidth])
               * DataWidth'(right_operand[HalfWidth-1:0]);
   end

   always_comb begin
      mag_a = a_ff[DataWidth-1] ? (-a_ff) : a_ff;
      mag_b = b_ff[DataWidth-1] ? (-b_ff) : b_ff;
      prod  = lo_ff + {cross_ff[HalfWidth-1:0], {HalfWidth{1'b0}}};
      slot_in         = '0;
      slot_in.valid   = valid_ff;
      slot_in.divisor = mag_b;
      slot_in.quot    = mag_a;
      slot_in.q_neg   = a_ff[DataWidth-1] ^ b_ff[DataWidth-1];
      slot_in.r_neg   = a_ff[DataWidth-1];
      slot_in.status  = ST_OK;
      case (op_ff)
         OP_ADD: slot_in.fixed = a_ff + b_ff;
         OP_SUB: slot_in.fixed = a_ff - b_ff;
         OP_MUL: slot_in.fixed = prod;
         OP_DIV: begin
            slot_in.is_div = 1'b1;
            if (b_ff == '0) begin
               slot_in.is_div = 1'b0;
               slot_in.status = ST_DIV_ZERO;
            end
         end
         OP_MOD: begin
            slot_in.is_div = 1'b1;
            slot_in.is_mod = 1'b1;
            slot_in.q_neg  = 1'b0;
            if (b_ff == '0) begin
               slot_in.is_div = 1'b0;
               slot_in.status = ST_MOD_ZERO;
            end
         end
         default: slot_in.status = ST_BAD_OP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         valid_ff      <= in_valid;
         slot_ff.valid <= slot_in.valid;
      end
      if (advance) begin
         op_ff    <= op;
         a_ff     <= left_operand;
         b_ff     <= right_operand;
         lo_ff    <= lo_in;
         cross_ff <= cross_in;
         slot_ff.is_div  <= slot_in.is_div;
         slot_ff.is_mod  <= slot_in.is_mod;
         slot_ff.q_neg   <= slot_in.q_neg;
         slot_ff.r_neg   <= slot_in.r_neg;
         slot_ff.status  <= slot_in.status;
         slot_ff.fixed   <= slot_in.fixed;
         slot_ff.divisor <= slot_in.divisor;
         slot_ff.quot    <= slot_in.quot;
         slot_ff.rem     <= slot_in.rem;
      end
   end

   assign slot_out = slot_ff;

endmodule

@@ verif/tb_integer_alu_add_sub_mul_div_mod_core.sv @@
// Testbench for the pipelined signed integer ALU: add, sub, mul, div, mod.
// Checks every result against an in-bench predictor through a FIFO of expected results.
// Depends on iaalu_pkg and integer_alu_add_sub_mul_div_mod_core.
module tb_integer_alu_add_sub_mul_div_mod_core;
   import iaalu_pkg::*;

   localparam int Latency    = DataWidth + 3;
   localparam int IdleLimit  = 20000;

   typedef struct packed {
      logic [StWidth-1:0]   status;
      logic [DataWidth-1:0] result;
   } alu_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   alu_out_type pending_results[$];
   int          mismatches;
   int          req_idle_pct;
   int          rsp_idle_pct;
   bit          hold_rsp;
   int          idle_cycles;

   integer_alu_add_sub_mul_div_mod_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic alu_out_type compute_alu(logic [OpWidth-1:0] op,
                                               logic signed [DataWidth-1:0] a,
                                               logic signed [DataWidth-1:0] b);
      alu_out_type o;
      logic [DataWidth-1:0] ua, ub, q, r;
      o.result = '0;
      o.status = ST_OK;
      ua = a[DataWidth-1] ? -a : a;
      ub = b[DataWidth-1] ? -b : b;
      q = '0;
      r = '0;
      if (ub != 0) begin
         q = ua / ub;
         r = ua % ub;
      end
      case (op)
         OP_ADD: o.result = a + b;
         OP_SUB: o.result = a - b;
         OP_MUL: o.result = a * b;
         OP_DIV: begin
            if (b == 0) o.status = ST_DIV_ZERO;
            else o.result = (a[DataWidth-1] != b[DataWidth-1]) ? -q : q;
         end
         OP_MOD: begin
            if (b == 0) o.status = ST_MOD_ZERO;
            else o.result = a[DataWidth-1] ? -r : r;
         end
         default: o.status = ST_BAD_OP;
      endcase
      return o;
   endfunction

   task automatic send_operation(logic [OpWidth-1:0] op, logic [DataWidth-1:0] a,
                                 logic [DataWidth-1:0] b);
      while (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, b, a, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(compute_alu(op, a, b));
   endtask

   // receiver side
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && !(rsp_idle_pct > 0 && $urandom_range(99) < rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      alu_out_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[33:0];
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_results.pop_front();
            if (got.result !== want.result || got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected result %h status %0d, got result %h status %0d",
                           want.result, want.status, got.result, got.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   function automatic logic [DataWidth-1:0] random_operand();
      case ($urandom_range(5))
         0: return {1'b1, {(DataWidth-1){1'b0}}};
         1: return {1'b0, {(DataWidth-1){1'b1}}};
         2: return $urandom_range(8) - 4;
         3: return $urandom_range(1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      logic [DataWidth-1:0] vmin, vmax, vm1;
      vmin = {1'b1, {(DataWidth-1){1'b0}}};
      vmax = {1'b0, {(DataWidth-1){1'b1}}};
      vm1  = '1;
      send_operation(OP_ADD, vmax, 1);
      send_operation(OP_ADD, vmin, vm1);
      send_operation(OP_SUB, vmin, 1);
      send_operation(OP_SUB, 0, vmin);
      send_operation(OP_MUL, vmax, vmax);
      send_operation(OP_MUL, vmin, vm1);
      send_operation(OP_DIV, vmin, vm1);
      send_operation(OP_MOD, vmin, vm1);
      send_operation(OP_DIV, 7, 0);
      send_operation(OP_MOD, 7, 0);
      send_operation(OP_DIV, -7, 2);
      send_operation(OP_MOD, -7, 2);
      send_operation(OP_DIV, 7, -2);
      send_operation(OP_MOD, 7, -2);
      send_operation(OP_DIV, vmax, vmin);
      send_operation(OP_MOD, vmin, vmax);
      send_operation(3'd5, vm1, vm1);
      send_operation(3'd6, 1, 2);
      send_operation(3'd7, vmin, vmax);
   endtask

   task automatic test_random(int count);
      repeat (count) begin
         send_operation(OpWidth'($urandom_range(7) < 6 ? $urandom_range(4) : $urandom_range(7)),
                        random_operand(), random_operand());
      end
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (4 * Latency) @(posedge clock);
            hold_rsp = 1'b0;
         end
         test_random(80);
      join
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && guard < IdleLimit) begin
         @(posedge clock);
         guard++;
      end
      repeat (Latency + 5) @(posedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      mismatches   = 0;
      hold_rsp     = 1'b0;
      req_idle_pct = 23;
      rsp_idle_pct = 58;
      idle_cycles  = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(250);
      req_idle_pct = 58;
      rsp_idle_pct = 23;
      test_random(250);
      test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_directed();
      test_random(250);
      drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
